/* src/lpfp_pkg.sv */
// Package for the length-prefixed frame parser.
// Holds phase and event codes, register indexes, reset values and the config struct.
// No dependencies.
package lpfp_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_BYTE   = 2'd2;

    localparam logic [7:0]  RST_EXP_VERSION = 8'h01;
    localparam logic [15:0] RST_MAX_PAYLOAD = 16'd1024;
    localparam logic [7:0]  RST_STOP_BYTE   = 8'h0A;

    typedef enum logic [2:0] {
        PH_VERSION = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_TERM    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_BUSY        = 3'd0,
        EV_DATA        = 3'd1,
        EV_OK          = 3'd2,
        EV_BAD_VERSION = 3'd3,
        EV_TOO_LONG    = 3'd4,
        EV_BAD_TERM    = 3'd5
    } t_event;

    typedef struct packed {
        logic [7:0]  exp_version;
        logic [15:0] max_payload;
        logic [7:0]  stop_byte;
    } t_cfg;

endpackage

/* src/lpfp_rx_if.sv */
// Input channel of the frame parser: one received byte per transfer.
// Valid/ready handshake; no dependencies.
interface lpfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* src/lpfp_res_if.sv */
// Result channel of the frame parser: one event per received byte.
// Valid/ready handshake; no dependencies.
interface lpfp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;

    modport source (output valid, output event_res, output data_byte, output frame_type,
                    output payload_length, input ready);
    modport sink   (input valid, input event_res, input data_byte, input frame_type,
                    input payload_length, output ready);
endinterface

/* src/length_prefixed_frame_parser.sv */
// Length-prefixed frame parser, top level.
// Depends on lpfp_pkg, lpfp_rx_if, lpfp_res_if and lpfp_cfg_regs.
//
// Frames are: version byte, type byte, 16-bit big-endian length, payload, terminator.
// i_rx carries one received byte per transfer; o_res returns exactly one event per
// byte: busy, payload byte (with data), frame ok, bad version, too long or bad
// terminator, together with the current frame type and length field.
// After any error the parser waits for a new version byte. A zero length goes
// straight to the terminator check.
// A byte's result is registered at its transfer and is on o_res in the next cycle.
// Throughput: one byte per cycle unless stalled; parse state and result register are
// both updated in the transfer cycle, so the next byte is taken right away.
// When the receiver stalls, the result register holds and i_rx.ready drops
// until the pending result is taken (ready follows o_res.ready combinationally
// while a result is pending).
// Reset (synchronous, active low) returns to waiting for a version byte, clears
// the frame fields, empties the result register and loads register defaults
// (version 0x01, limit 1024, terminator 0x0A). The user writes configuration via
// i_cfg_we / i_cfg_idx / i_cfg_data only while the parser is idle; not enforced.
module length_prefixed_frame_parser
    import lpfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lpfp_rx_if.sink               i_rx,
    lpfp_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;

    lpfp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_type_hold,   n_type_hold;
    logic [7:0]  r_length_high, n_length_high;
    logic [15:0] r_length_hold, n_length_hold;
    logic [15:0] r_bytes_left,  n_bytes_left;

    logic        r_out_valid;
    t_event      r_ev,   n_ev;
    logic [7:0]  r_data, n_data;

    logic        rx_xfer;
    logic [15:0] len_word;
    logic [15:0] left_dec;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign rx_xfer    = i_rx.valid && i_rx.ready;
    assign len_word   = {r_length_high, i_rx.rx_byte};
    assign left_dec   = r_bytes_left - 16'd1;

    always_comb begin
        n_phase       = r_phase;
        n_type_hold   = r_type_hold;
        n_length_high = r_length_high;
        n_length_hold = r_length_hold;
        n_bytes_left  = r_bytes_left;
        n_ev          = EV_BUSY;
        n_data        = 8'd0;
        unique case (r_phase)
            PH_TYPE: begin
                n_type_hold = i_rx.rx_byte;
                n_phase     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length_high = i_rx.rx_byte;
                n_phase       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length_hold = len_word;
                if (len_word > cfg.max_payload) begin
                    n_ev    = EV_TOO_LONG;
                    n_phase = PH_VERSION;
                end else if (len_word == 16'd0) begin
                    n_phase = PH_TERM;
                end else begin
                    n_bytes_left = len_word;
                    n_phase      = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_ev         = EV_DATA;
                n_data       = i_rx.rx_byte;
                n_bytes_left = left_dec;
                if (left_dec == 16'd0) begin
                    n_phase = PH_TERM;
                end
            end
            PH_TERM: begin
                n_ev    = (i_rx.rx_byte == cfg.stop_byte) ? EV_OK : EV_BAD_TERM;
                n_phase = PH_VERSION;
            end
            default: begin
                n_type_hold   = 8'd0;
                n_length_hold = 16'd0;
                if (i_rx.rx_byte == cfg.exp_version) begin
                    n_phase = PH_TYPE;
                end else begin
                    n_ev    = EV_BAD_VERSION;
                    n_phase = PH_VERSION;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_VERSION;
            r_type_hold   <= 8'd0;
            r_length_high <= 8'd0;
            r_length_hold <= 16'd0;
            r_bytes_left  <= 16'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (rx_xfer) begin
                r_phase       <= n_phase;
                r_type_hold   <= n_type_hold;
                r_length_high <= n_length_high;
                r_length_hold <= n_length_hold;
                r_bytes_left  <= n_bytes_left;
                r_out_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_xfer) begin
            r_ev   <= n_ev;
            r_data <= n_data;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.event_res      = r_ev;
    assign o_res.data_byte      = r_data;
    assign o_res.frame_type     = r_type_hold;
    assign o_res.payload_length = r_length_hold;

    // payload phase always has bytes outstanding, bounded by the length field
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> (r_bytes_left != 16'd0) && (r_bytes_left <= r_length_hold))
        else $error("payload countdown out of range");

    a_term_to_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_xfer && r_phase == PH_TERM |=> r_phase == PH_VERSION)
        else $error("terminator did not return to version phase");

    a_data_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.event_res != EV_DATA |-> o_res.data_byte == 8'd0)
        else $error("data byte set outside payload event");

    a_error_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_xfer && (n_ev == EV_BAD_VERSION || n_ev == EV_TOO_LONG || n_ev == EV_BAD_TERM)
        |=> r_phase == PH_VERSION)
        else $error("error did not return to version phase");

    a_version_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_xfer && r_phase == PH_VERSION |=> r_type_hold == 8'd0 && r_length_hold == 16'd0)
        else $error("version byte did not clear frame fields");

endmodule

/* src/lpfp_cfg_regs.sv */
// Configuration registers of the frame parser: version, payload limit, terminator.
// Depends on lpfp_pkg.
module lpfp_cfg_regs
    import lpfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EXP_VERSION: n_cfg.exp_version = i_cfg_data[7:0];
                CFG_MAX_PAYLOAD: n_cfg.max_payload = i_cfg_data[15:0];
                CFG_STOP_BYTE:   n_cfg.stop_byte   = i_cfg_data[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp_version <= RST_EXP_VERSION;
            r_cfg.max_payload <= RST_MAX_PAYLOAD;
            r_cfg.stop_byte   <= RST_STOP_BYTE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
